// ----- sv/mfs_pkg.sv -----
// Shared types and codes for the maximum-frequency stack.
// Used by mfs_count_table and max_frequency_stack_core; depends on nothing.
package mfs_pkg;

  // Width of a stored value; the count table has one entry per value
  localparam int VALUE_BITS = 8;
  localparam int NUM_VALUES = 1 << VALUE_BITS;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                  cmd;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] popped_value;
    logic                  pop_valid;
    logic [1:0]            status;
  } out_item_t;

endpackage

// ----- sv/mfs_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the level tops, the entry links and the recycled slot stack.
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/mfs_count_table.sv -----
// Per-value occurrence count table: a RAM plus one valid bit per entry.
// An entry never written reads as zero. Depends on mfs_pkg.
module mfs_count_table #(
  parameter int CNT_W = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [mfs_pkg::VALUE_BITS-1:0] rd_addr,
  output logic [CNT_W-1:0]              rd_data,
  input  logic                          wr_en,
  input  logic [mfs_pkg::VALUE_BITS-1:0] wr_addr,
  input  logic [CNT_W-1:0]              wr_data
);

  logic [CNT_W-1:0]              mem [mfs_pkg::NUM_VALUES];
  logic [mfs_pkg::NUM_VALUES-1:0] vld_r;
  logic [CNT_W-1:0]              rd_q_r;
  logic                          rd_vld_r;

  // Count storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- sv/max_frequency_stack_core.sv -----
// Maximum-frequency stack: top level with the command sequencer.
// Depends on mfs_pkg, mfs_ram and mfs_count_table.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries a push of a value or
//   a pop of the most frequent value (latest pushed wins ties). Each command
//   gives exactly one result on the output channel (out_valid / out_stall /
//   out_data): the popped value with pop_valid set, or a status of pop on
//   empty or push when full, which leave the state unchanged.
//   Commands run one at a time through read-modify-write passes over the
//   count table and the level, entry and free-slot RAMs (registered reads).
//   A push steps through S_PA and S_PB, a pop through S_QA, S_QB and S_QC,
//   a rejected command through S_DONE; each then writes the result register
//   and returns to S_IDLE, where the next command is taken. No new command
//   is taken before the last one has written its result.
//   The result register lets the sequencer start the next command while a
//   result waits; if out_stall holds it, the following command waits in its
//   final step and in_stall stays high.
//   Reset (rst_n low, synchronous) empties the stack at once; no clearing
//   pass is needed.
module max_frequency_stack_core #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mfs_pkg::out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VB = mfs_pkg::VALUE_BITS;
  localparam int EW = VB + AW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PA,
    S_PB,
    S_QA,
    S_QB,
    S_QC,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [VB-1:0]      val_r, val_nxt;
  logic [CW-1:0]      c_r, c_nxt;
  logic [AW-1:0]      s_r, s_nxt;
  logic [VB-1:0]      x_r, x_nxt;
  logic [AW-1:0]      b_r, b_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [CW-1:0]      max_r, max_nxt;
  logic [CW-1:0]      fresh_r, fresh_nxt;
  logic [CW-1:0]      rec_r, rec_nxt;
  logic               out_valid_r, out_valid_nxt;
  mfs_pkg::out_item_t out_data_r, out_data_nxt;

  logic [CW-1:0] free_cnt;
  logic [CW-1:0] max_m1, rec_m1, fresh_m1, c_m1;
  logic          out_free;
  logic          occupied;

  // Memory port controls
  logic          cnt_re, cnt_we;
  logic [VB-1:0] cnt_ra, cnt_wa;
  logic [CW-1:0] cnt_wd, cnt_rd;
  logic          lt_re, lt_we;
  logic [AW-1:0] lt_ra, lt_wa, lt_wd, lt_rd;
  logic          ent_re, ent_we;
  logic [AW-1:0] ent_ra, ent_wa;
  logic [EW-1:0] ent_wd, ent_rd;
  logic          rec_re, rec_we;
  logic [AW-1:0] rec_ra, rec_wa, rec_wd, rec_rd;

  mfs_count_table #(.CNT_W(CW)) u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cnt_re),
    .rd_addr (cnt_ra),
    .rd_data (cnt_rd),
    .wr_en   (cnt_we),
    .wr_addr (cnt_wa),
    .wr_data (cnt_wd)
  );

  // Top slot of each level, addressed by level - 1
  mfs_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_level_top (
    .clk     (clk),
    .wr_en   (lt_we),
    .wr_addr (lt_wa),
    .wr_data (lt_wd),
    .rd_en   (lt_re),
    .rd_addr (lt_ra),
    .rd_data (lt_rd)
  );

  // Entry slots: {value, slot below}
  mfs_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_entry (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_wa),
    .wr_data (ent_wd),
    .rd_en   (ent_re),
    .rd_addr (ent_ra),
    .rd_data (ent_rd)
  );

  // Stack of slots returned by pops
  mfs_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_recycle (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (rec_wa),
    .wr_data (rec_wd),
    .rd_en   (rec_re),
    .rd_addr (rec_ra),
    .rd_data (rec_rd)
  );

  // Free slots: never-used ones counted down, plus the recycled stack
  assign free_cnt = fresh_r + rec_r;
  assign max_m1   = max_r - ONE_C;
  assign rec_m1   = rec_r - ONE_C;
  assign fresh_m1 = fresh_r - ONE_C;
  assign c_m1     = c_r - ONE_C;
  assign out_free = !out_valid_r || !out_stall;
  // Levels 1..max are always non-empty
  assign occupied = (c_r <= max_r);

  // Sequencer next state and memory accesses
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    x_nxt         = x_r;
    b_nxt         = b_r;
    status_nxt    = status_r;
    max_nxt       = max_r;
    fresh_nxt     = fresh_r;
    rec_nxt       = rec_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    cnt_re = 1'b0;
    cnt_ra = val_r;
    cnt_we = 1'b0;
    cnt_wa = val_r;
    cnt_wd = c_r;
    lt_re  = 1'b0;
    lt_ra  = max_m1[AW-1:0];
    lt_we  = 1'b0;
    lt_wa  = c_m1[AW-1:0];
    lt_wd  = s_r;
    ent_re = 1'b0;
    ent_ra = s_r;
    ent_we = 1'b0;
    ent_wa = s_r;
    ent_wd = {val_r, s_r};
    rec_re = 1'b0;
    rec_ra = rec_m1[AW-1:0];
    rec_we = 1'b0;
    rec_wa = rec_r[AW-1:0];
    rec_wd = s_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_data.value;
          if (in_data.cmd == mfs_pkg::CMD_PUSH) begin
            if (free_cnt == '0) begin
              status_nxt = mfs_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cnt_re    = 1'b1;
              cnt_ra    = in_data.value;
              rec_re    = (rec_r != '0);
              state_nxt = S_PA;
            end
          end else begin
            if (max_r == '0) begin
              status_nxt = mfs_pkg::ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              lt_re     = 1'b1;
              state_nxt = S_QA;
            end
          end
        end
      end
      // Push: new level, pick a slot, fetch that level's top
      S_PA: begin
        c_nxt     = cnt_rd + ONE_C;
        s_nxt     = (rec_r != '0) ? rec_rd : fresh_m1[AW-1:0];
        lt_re     = 1'b1;
        lt_ra     = cnt_rd[AW-1:0];
        state_nxt = S_PB;
      end
      // Push: link the slot on its level and commit
      S_PB: begin
        if (out_free) begin
          ent_we = 1'b1;
          ent_wd = {val_r, (occupied ? lt_rd : s_r)};
          lt_we  = 1'b1;
          cnt_we = 1'b1;
          if (rec_r != '0) begin
            rec_nxt = rec_m1;
          end else begin
            fresh_nxt = fresh_m1;
          end
          if (c_r > max_r) begin
            max_nxt = c_r;
          end
          out_valid_nxt             = 1'b1;
          out_data_nxt.popped_value = '0;
          out_data_nxt.pop_valid    = 1'b0;
          out_data_nxt.status       = mfs_pkg::ST_OK;
          state_nxt                 = S_IDLE;
        end
      end
      // Pop: top slot known, fetch its entry
      S_QA: begin
        s_nxt     = lt_rd;
        ent_re    = 1'b1;
        ent_ra    = lt_rd;
        state_nxt = S_QB;
      end
      // Pop: value and link known, fetch the value's count
      S_QB: begin
        x_nxt     = ent_rd[EW-1:AW];
        b_nxt     = ent_rd[AW-1:0];
        cnt_re    = 1'b1;
        cnt_ra    = ent_rd[EW-1:AW];
        state_nxt = S_QC;
      end
      // Pop: unlink, lower the count, recycle the slot and commit
      S_QC: begin
        if (out_free) begin
          if (b_r == s_r) begin
            max_nxt = max_m1;
          end else begin
            lt_we = 1'b1;
            lt_wa = max_m1[AW-1:0];
            lt_wd = b_r;
          end
          cnt_we = 1'b1;
          cnt_wa = x_r;
          cnt_wd = (cnt_rd != '0) ? (cnt_rd - ONE_C) : '0;
          if (free_cnt < DEPTH_C) begin
            rec_we  = 1'b1;
            rec_nxt = rec_r + ONE_C;
          end
          out_valid_nxt             = 1'b1;
          out_data_nxt.popped_value = x_r;
          out_data_nxt.pop_valid    = 1'b1;
          out_data_nxt.status       = mfs_pkg::ST_OK;
          state_nxt                 = S_IDLE;
        end
      end
      // Rejected command: report only
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.popped_value = '0;
          out_data_nxt.pop_valid    = 1'b0;
          out_data_nxt.status       = status_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and result register
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    x_r        <= x_nxt;
    b_r        <= b_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= '0;
      fresh_r     <= DEPTH_C;
      rec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_r       <= max_nxt;
      fresh_r     <= fresh_nxt;
      rec_r       <= rec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Free slot count never exceeds the slot memory
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt <= DEPTH_C)
    else $error("free slot count above depth");

  // Highest level is bounded by the slots in use
  a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, max_r} + {1'b0, free_cnt}) <= (CW + 1)'(DEPTH))
    else $error("max level exceeds allocated entries");

  // A committed push takes exactly one slot
  a_push_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PB && out_free) |=> free_cnt == $past(free_cnt) - ONE_C)
    else $error("push did not allocate one slot");

  // A committed pop returns exactly one slot
  a_pop_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QC && out_free) |=> free_cnt == $past(free_cnt) + ONE_C)
    else $error("pop did not release one slot");

  // A popped value always comes with an ok status
  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pop_valid) |-> out_data_r.status == mfs_pkg::ST_OK)
    else $error("pop result with error status");
`endif

endmodule
